// ----- rtl/rgk_pkg.sv -----
package rgk_pkg;

   localparam int VALUE_W = 32;
   localparam int CSR_W   = 5;

   localparam logic [CSR_W-1:0] GROUP_SIZE_RESET = 5'd1;

   // one list element as it arrives
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      list_end;
   } req_type;

   // one element of the reordered list
   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic                      run_end;
      logic                      out_list_end;
   } rsp_type;

endpackage

// ----- rtl/rgk_queue.sv -----
module rgk_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/rgk_front.sv -----
module rgk_front import rgk_pkg::*; #(
   parameter  int MAX_GROUP = 16,
   localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
   localparam int CNT_W     = $clog2(MAX_GROUP + 1),
   localparam int JOB_W     = CNT_W + 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_W-1:0]   csr_wdata,
   input  logic               rel_valid,
   input  logic               rel_bank,
   input  logic               q_full,
   output logic               push_valid,
   output logic [JOB_W-1:0]   push_job,
   output logic               mem_we,
   output logic [IDX_W:0]     mem_waddr,
   output logic [VALUE_W-1:0] mem_wdata
);

   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic             rev;
      logic             lend;
   } job_type;

   logic [CSR_W-1:0] group_size_ff;
   logic [CMP_W-1:0] group_raw;
   logic [CMP_W-1:0] group_eff;
   logic [IDX_W-1:0] fill_ff;
   logic [IDX_W-1:0] fill_in;
   logic             bank_ff;
   logic             bank_in;
   logic [1:0]       busy_ff;
   logic [1:0]       busy_in;
   logic [CNT_W-1:0] held;
   logic             full_group;
   logic             done;
   logic             accept;
   job_type          job;

   assign csr_ready = 1'b1;

   // group size register
   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= GROUP_SIZE_RESET;
      end else if (csr_valid) begin
         group_size_ff <= csr_wdata;
      end
   end

   // zero means one, anything above MAX_GROUP means MAX_GROUP
   always_comb begin
      group_raw = CMP_W'(group_size_ff);
      group_eff = group_raw;
      if (group_raw == '0) begin
         group_eff = CMP_W'(1);
      end else if (group_raw > CMP_W'(MAX_GROUP)) begin
         group_eff = CMP_W'(MAX_GROUP);
      end
   end

   // classify the incoming element
   assign req_ready  = !busy_ff[bank_ff] && !q_full;
   assign accept     = req_valid && req_ready;
   assign held       = CNT_W'(fill_ff) + CNT_W'(1);
   assign full_group = (CMP_W'(held) >= group_eff);
   assign done       = full_group || req_data.list_end;

   assign job.bank  = bank_ff;
   assign job.count = held;
   assign job.rev   = full_group;
   assign job.lend  = req_data.list_end;

   assign push_valid = accept && done;
   assign push_job   = job;

   assign mem_we    = accept;
   assign mem_waddr = {bank_ff, fill_ff};
   assign mem_wdata = req_data.value;

   // fill position, bank flip and bank ownership
   always_comb begin
      fill_in = fill_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (rel_valid) begin
         busy_in[rel_bank] = 1'b0;
      end
      if (accept) begin
         if (done) begin
            fill_in          = '0;
            bank_in          = !bank_ff;
            busy_in[bank_ff] = 1'b1;
         end else begin
            fill_in = IDX_W'(held);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bank_ff <= 1'b0;
         busy_ff <= 2'b00;
      end else begin
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ----- rtl/rgk_back.sv -----
module rgk_back import rgk_pkg::*; #(
   parameter  int MAX_GROUP = 16,
   localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
   localparam int CNT_W     = $clog2(MAX_GROUP + 1),
   localparam int JOB_W     = CNT_W + 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               mem_we,
   input  logic [IDX_W:0]     mem_waddr,
   input  logic [VALUE_W-1:0] mem_wdata,
   input  logic               q_valid,
   input  logic [JOB_W-1:0]   q_job,
   output logic               q_pop,
   output logic               rel_valid,
   output logic               rel_bank,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);

   localparam int DEPTH = 2 * (1 << IDX_W);

   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic             rev;
      logic             lend;
   } job_type;

   logic [VALUE_W-1:0] mem [DEPTH];

   job_type            job_ff;
   job_type            q_head;
   logic               active_ff;
   logic [IDX_W-1:0]   pos_ff;
   logic               s1_valid_ff;
   logic               s1_last_ff;
   logic               s1_lend_ff;
   logic [VALUE_W-1:0] s1_data_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               out_free;
   logic               s1_free;
   logic               issue;
   logic               at_last;
   logic               last_issue;
   logic [IDX_W-1:0]   rd_idx;
   logic [CNT_W-1:0]   rev_idx;

   assign q_head = q_job;

   // pipeline advance
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_free    = !s1_valid_ff || out_free;
   assign issue      = active_ff && s1_free;
   assign at_last    = (CNT_W'(pos_ff) + CNT_W'(1) == job_ff.count);
   assign last_issue = issue && at_last;
   assign q_pop      = q_valid && (!active_ff || last_issue);

   // bank is free once its last element has been read
   assign rel_valid = last_issue;
   assign rel_bank  = job_ff.bank;

   // read order: newest first for a full group, arrival order otherwise
   assign rev_idx = job_ff.count - CNT_W'(1) - CNT_W'(pos_ff);
   assign rd_idx  = job_ff.rev ? IDX_W'(rev_idx) : pos_ff;

   // job sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
      end else if (q_pop) begin
         active_ff <= 1'b1;
         pos_ff    <= '0;
      end else if (last_issue) begin
         active_ff <= 1'b0;
      end else if (issue) begin
         pos_ff <= pos_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_head;
      end
   end

   // ping-pong element buffer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_data_ff <= mem[{job_ff.bank, rd_idx}];
      end
   end

   // read stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_last_ff <= last_issue;
         s1_lend_ff <= last_issue && job_ff.lend;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff.out_value    <= s1_data_ff;
         rsp_data_ff.run_end      <= s1_last_ff;
         rsp_data_ff.out_list_end <= s1_lend_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/reverse_in_groups_of_k.sv -----
// Reverses a list in groups of k elements.
// req_*: one signed 32-bit element per request, list_end on the final one.
// csr_*: write of group_size (1..16; 0 acts as 1, above MAX_GROUP as
//   MAX_GROUP); csr_ready is always high, write only while the block is idle.
// rsp_*: reordered elements; a full group comes out newest first, a partial
//   group at list end in arrival order. run_end marks the last result of a
//   burst, out_list_end the final element of the list.
// Results: once a burst's job leaves the queue, its elements pass the read
//   stage and output register, one per cycle unless rsp_ready stalls them.
// Elements land in one half of a two-bank buffer while the back end reads the
//   other, so new requests are taken while a burst is read out; after each
//   group the front stalls until the bank it returns to has been read out.
// Reset clears the fill count, bank ownership, the job queue and the output
//   stages and sets group_size to 1; buffer contents are not cleared.
// A stall on rsp_ready holds the output register, then the read stage, then
//   the job queue; the front keeps taking requests until both banks are full.
module reverse_in_groups_of_k import rgk_pkg::*; #(
   parameter int MAX_GROUP = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int CNT_W = $clog2(MAX_GROUP + 1);
   localparam int JOB_W = CNT_W + 3;

   logic               rel_valid;
   logic               rel_bank;
   logic               q_full;
   logic               push_valid;
   logic [JOB_W-1:0]   push_job;
   logic               q_valid;
   logic [JOB_W-1:0]   q_job;
   logic               q_pop;
   logic               mem_we;
   logic [IDX_W:0]     mem_waddr;
   logic [VALUE_W-1:0] mem_wdata;

   // accept and classify elements
   rgk_front #(.MAX_GROUP(MAX_GROUP)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .rel_valid  (rel_valid),
      .rel_bank   (rel_bank),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_job   (push_job),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata)
   );

   // burst jobs between front and back
   rgk_queue #(.WIDTH(JOB_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_data  (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_job)
   );

   // buffer read-out and result stream
   rgk_back #(.MAX_GROUP(MAX_GROUP)) u_back (
      .clock      (clock),
      .reset      (reset),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .q_valid    (q_valid),
      .q_job      (q_job),
      .q_pop      (q_pop),
      .rel_valid  (rel_valid),
      .rel_bank   (rel_bank),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- rtl/rgk_check.sv -----
module rgk_check import rgk_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // the end of the list is always the end of a burst
   a_lend_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.out_list_end || rsp_data.run_end))
      else $error("out_list_end without run_end");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled request stays offered with the same payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request dropped or changed while stalled");

endmodule

bind reverse_in_groups_of_k rgk_check u_rgk_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
